// ===== sv/z85_pkg.sv =====
// shared types, constants and symbol tables for the z85 codec
`timescale 1ns / 1ps

package z85_pkg;

    // group sizes and result counts
    localparam logic [2:0] Z85_CHARS   = 3'd5;
    localparam logic [2:0] Z85_BYTES   = 3'd4;
    localparam logic [2:0] Z85_ERR_LEN = 3'd1;

    // radix and reciprocal: floor(x / 85) == (x * Z85_RECIP) >> Z85_RECIP_SHIFT for 32-bit x
    localparam logic [31:0] Z85_RADIX       = 32'd85;
    localparam logic [31:0] Z85_RECIP       = 32'd3233857729;
    localparam int          Z85_RECIP_SHIFT = 38;

    // queue between front and back
    localparam int Z85_QDEPTH = 2;
    localparam int Z85_QPTR_W = $clog2(Z85_QDEPTH);
    localparam int Z85_QCNT_W = $clog2(Z85_QDEPTH + 1);

    // input request
    typedef struct packed {
        logic [7:0] in_symbol;
        logic       end_of_stream;
    } t_in_req;

    // output request
    typedef struct packed {
        logic [7:0] out_symbol;
        logic       group_last;
        logic       stream_last;
        logic       length_error;
        logic       bad_char;
    } t_out_req;

    // work handed from front to back
    typedef enum logic [1:0] {
        JOB_ENC,
        JOB_DEC,
        JOB_ERR
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic [31:0] word;
        logic        eos;
        logic        bad;
    } t_job;

    // digit value to z85 character
    function automatic logic [7:0] z85_char(input logic [6:0] d);
        logic [7:0] c;
        c = 8'h00;
        if (d < 7'd10) begin
            c = 8'h30 + {1'b0, d};
        end else if (d < 7'd36) begin
            c = 8'h61 + {1'b0, d} - 8'd10;
        end else if (d < 7'd62) begin
            c = 8'h41 + {1'b0, d} - 8'd36;
        end else begin
            case (d)
                7'd62:   c = 8'h2E;
                7'd63:   c = 8'h2D;
                7'd64:   c = 8'h3A;
                7'd65:   c = 8'h2B;
                7'd66:   c = 8'h3D;
                7'd67:   c = 8'h5E;
                7'd68:   c = 8'h21;
                7'd69:   c = 8'h2F;
                7'd70:   c = 8'h2A;
                7'd71:   c = 8'h3F;
                7'd72:   c = 8'h26;
                7'd73:   c = 8'h3C;
                7'd74:   c = 8'h3E;
                7'd75:   c = 8'h28;
                7'd76:   c = 8'h29;
                7'd77:   c = 8'h5B;
                7'd78:   c = 8'h5D;
                7'd79:   c = 8'h7B;
                7'd80:   c = 8'h7D;
                7'd81:   c = 8'h40;
                7'd82:   c = 8'h25;
                7'd83:   c = 8'h24;
                7'd84:   c = 8'h23;
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

    // z85 character to digit value, unknown codes give zero
    function automatic logic [6:0] z85_digit(input logic [7:0] c);
        logic [6:0] d;
        d = 7'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = 7'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = 7'(c - 8'h61 + 8'd10);
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            d = 7'(c - 8'h41 + 8'd36);
        end else begin
            case (c)
                8'h2E:   d = 7'd62;
                8'h2D:   d = 7'd63;
                8'h3A:   d = 7'd64;
                8'h2B:   d = 7'd65;
                8'h3D:   d = 7'd66;
                8'h5E:   d = 7'd67;
                8'h21:   d = 7'd68;
                8'h2F:   d = 7'd69;
                8'h2A:   d = 7'd70;
                8'h3F:   d = 7'd71;
                8'h26:   d = 7'd72;
                8'h3C:   d = 7'd73;
                8'h3E:   d = 7'd74;
                8'h28:   d = 7'd75;
                8'h29:   d = 7'd76;
                8'h5B:   d = 7'd77;
                8'h5D:   d = 7'd78;
                8'h7B:   d = 7'd79;
                8'h7D:   d = 7'd80;
                8'h40:   d = 7'd81;
                8'h25:   d = 7'd82;
                8'h24:   d = 7'd83;
                8'h23:   d = 7'd84;
                default: d = 7'd0;
            endcase
        end
        return d;
    endfunction

endpackage

// ===== sv/base85_z85_codec_top.sv =====
// top level of the streaming z85 codec
`timescale 1ns / 1ps

// Streaming Z85 codec. Input requests (i_in_valid / o_in_stall, payload i_in_req) carry
// one byte when encoding or one character when decoding, plus an end-of-stream flag.
// Output requests (o_out_valid / i_out_stall, payload o_out_req) carry one character
// or byte each, with group-last, stream-last, length-error and bad-character flags.
// i_cfg_we writes i_cfg_data into the mode bit (1 = decode) and drops any partial
// group; write it only while the block is idle.
// A stream ending inside a group gives one error request.
// Throughput: decoding takes one character per cycle while the job queue has room.
// Encoding is bound by the output channel, which carries five characters per group,
// and by the digit extractor (one reciprocal multiply per step, one digit per cycle
// unless the burst hand-off slot is full, the last step giving two digits).
// Reset (synchronous, active low) clears the mode to encode and empties all stages.
// When the receiver stalls, the output register holds its request; the two-entry job
// queue fills and o_in_stall rises only once the queue is full.

module base85_z85_codec_top import z85_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  logic     i_cfg_data,
    input  logic     i_in_valid,
    input  t_in_req  i_in_req,
    output logic     o_in_stall,
    output logic     o_out_valid,
    output t_out_req o_out_req,
    input  logic     i_out_stall
);

    logic q_push;
    t_job q_push_data;
    logic q_full;
    logic q_valid;
    t_job q_data;
    logic q_pop;

    // request intake and group assembly
    z85_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_in_valid),
        .i_req      (i_in_req),
        .o_stall    (o_in_stall),
        .o_push     (q_push),
        .o_job      (q_push_data),
        .i_q_full   (q_full)
    );

    // job queue
    z85_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_data      (q_data),
        .i_pop       (q_pop)
    );

    // conversion and output
    z85_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_data),
        .o_pop       (q_pop),
        .o_valid     (o_out_valid),
        .o_req       (o_out_req),
        .i_stall     (i_out_stall)
    );

endmodule

// ===== sv/z85_front.sv =====
// front end: accepts requests, packs or accumulates groups, issues jobs
`timescale 1ns / 1ps

module z85_front import z85_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  logic    i_cfg_data,
    input  logic    i_valid,
    input  t_in_req i_req,
    output logic    o_stall,
    output logic    o_push,
    output t_job    o_job,
    input  logic    i_q_full
);

    logic        r_mode;
    logic [31:0] r_acc;
    logic [2:0]  r_cnt;
    logic        r_bad;

    logic        accept;
    logic [6:0]  digit;
    logic        bad_now;
    logic [31:0] mac;
    logic [31:0] n_acc;
    logic [2:0]  n_cnt;
    logic        n_bad;
    logic        complete;

    // accept whenever the job queue has room
    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;

    // digit lookup and group accumulation
    always_comb begin
        digit    = z85_digit(i_req.in_symbol);
        bad_now  = r_mode && (i_req.in_symbol[7] || i_req.in_symbol[7:5] == 3'b000);
        mac      = 32'(r_acc * Z85_RADIX) + {25'd0, digit};
        n_acc    = r_mode ? mac : {r_acc[23:0], i_req.in_symbol};
        n_bad    = r_bad | bad_now;
        n_cnt    = r_cnt + 3'd1;
        complete = (n_cnt == (r_mode ? Z85_CHARS : Z85_BYTES));
    end

    // job issue on a full group or an early end of stream
    always_comb begin
        o_push     = accept && (complete || i_req.end_of_stream);
        o_job.kind = complete ? (r_mode ? JOB_DEC : JOB_ENC) : JOB_ERR;
        o_job.word = n_acc;
        o_job.eos  = i_req.end_of_stream;
        o_job.bad  = n_bad;
    end

    // mode and group state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_acc  <= 32'd0;
            r_cnt  <= 3'd0;
            r_bad  <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
            r_acc  <= 32'd0;
            r_cnt  <= 3'd0;
            r_bad  <= 1'b0;
        end else if (accept) begin
            if (o_push) begin
                r_acc <= 32'd0;
                r_cnt <= 3'd0;
                r_bad <= 1'b0;
            end else begin
                r_acc <= n_acc;
                r_cnt <= n_cnt;
                r_bad <= n_bad;
            end
        end
    end

    // group count stays below the group size
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < (r_mode ? Z85_CHARS : Z85_BYTES))
        else $error("group count out of range");

    // encoding never collects a bad-character flag
    a_enc_no_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_mode |-> !r_bad)
        else $error("bad flag set in encode mode");

endmodule

// ===== sv/z85_fifo.sv =====
// short job queue between the front end and the back end
`timescale 1ns / 1ps

module z85_fifo import z85_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_data,
    output logic o_full,
    output logic o_valid,
    output t_job o_data,
    input  logic i_pop
);

    t_job                  r_mem [Z85_QDEPTH];
    logic [Z85_QPTR_W-1:0] r_wptr;
    logic [Z85_QPTR_W-1:0] r_rptr;
    logic [Z85_QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == Z85_QCNT_W'(Z85_QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == Z85_QPTR_W'(Z85_QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == Z85_QPTR_W'(Z85_QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/z85_back.sv =====
// back end: radix conversion, result bursts and the output register
`timescale 1ns / 1ps

module z85_back import z85_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_job_valid,
    input  t_job     i_job,
    output logic     o_pop,
    output logic     o_valid,
    output t_out_req o_req,
    input  logic     i_stall
);

    typedef struct packed {
        logic [4:0][7:0] sym;
        logic [2:0]      n;
        logic            eos;
        logic            bad;
        logic            lerr;
    } t_burst;

    // converter
    logic            r_busy;
    logic [1:0]      r_step;
    logic [63:0]     r_prod;
    logic [31:0]     r_x;
    logic            r_ceos;
    logic [4:0][7:0] r_cdig;

    // burst hand-off slot
    logic            r_burst_valid;
    t_burst          r_burst;

    // emitter and output register
    logic            r_evalid;
    t_burst          r_emit;
    logic [2:0]      r_eidx;
    logic            r_out_valid;
    t_out_req        r_out;

    logic [25:0]     q;
    logic [31:0]     rem;
    logic [6:0]      digit;
    logic [2:0]      pos;
    logic [63:0]     n_prod;
    logic [63:0]     load_prod;
    logic            out_take;
    logic            e_last;
    logic            e_fire;
    logic            burst_take;
    logic            burst_free;
    logic            conv_done;
    logic            conv_adv;
    logic            pop_enc;
    logic            pop_direct;
    t_burst          enc_burst;
    t_burst          dir_burst;

    // a base-85 digit per cycle if the slot is free, least significant first
    always_comb begin
        q         = r_prod[63:Z85_RECIP_SHIFT];
        rem       = r_x - ({6'd0, q} * Z85_RADIX);
        digit     = rem[6:0];
        pos       = 3'd4 - {1'b0, r_step};
        n_prod    = {32'd0, 6'd0, q} * {32'd0, Z85_RECIP};
        load_prod = {32'd0, i_job.word} * {32'd0, Z85_RECIP};
    end

    // emitter and hand-off control
    always_comb begin
        out_take   = !r_out_valid || !i_stall;
        e_last     = (r_eidx == 3'(r_emit.n - 3'd1));
        e_fire     = r_evalid && out_take;
        burst_take = r_burst_valid && (!r_evalid || (e_fire && e_last));
        burst_free = !r_burst_valid || burst_take;
        conv_done  = r_busy && (r_step == 2'd3) && burst_free;
        conv_adv   = r_busy && ((r_step != 2'd3) || burst_free);
    end

    // job pops: encode jobs enter the converter, others go straight to a burst
    always_comb begin
        pop_enc    = i_job_valid && (i_job.kind == JOB_ENC) && (!r_busy || conv_done);
        pop_direct = i_job_valid && (i_job.kind != JOB_ENC) && !r_busy && burst_free;
        o_pop      = pop_enc || pop_direct;
    end

    // burst built from a finished conversion
    always_comb begin
        enc_burst.sym    = r_cdig;
        enc_burst.sym[1] = z85_char(digit);
        enc_burst.sym[0] = z85_char(q[6:0]);
        enc_burst.n      = Z85_CHARS;
        enc_burst.eos    = r_ceos;
        enc_burst.bad    = 1'b0;
        enc_burst.lerr   = 1'b0;
    end

    // burst built directly from a decode or error job
    always_comb begin
        dir_burst.sym  = '0;
        dir_burst.n    = Z85_ERR_LEN;
        dir_burst.eos  = i_job.eos;
        dir_burst.bad  = i_job.bad;
        dir_burst.lerr = 1'b1;
        case (i_job.kind)
            JOB_DEC: begin
                dir_burst.sym[0] = i_job.word[31:24];
                dir_burst.sym[1] = i_job.word[23:16];
                dir_burst.sym[2] = i_job.word[15:8];
                dir_burst.sym[3] = i_job.word[7:0];
                dir_burst.n      = Z85_BYTES;
                dir_burst.lerr   = 1'b0;
            end
            default: begin
                dir_burst.n    = Z85_ERR_LEN;
                dir_burst.lerr = 1'b1;
            end
        endcase
    end

    // converter datapath
    always_ff @(posedge i_clk) begin
        if (pop_enc) begin
            r_prod <= load_prod;
            r_x    <= i_job.word;
            r_ceos <= i_job.eos;
        end else if (conv_adv) begin
            r_prod      <= n_prod;
            r_x         <= {6'd0, q};
            r_cdig[pos] <= z85_char(digit);
        end
    end

    // converter control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 2'd0;
        end else if (pop_enc) begin
            r_busy <= 1'b1;
            r_step <= 2'd0;
        end else if (conv_done) begin
            r_busy <= 1'b0;
        end else if (conv_adv) begin
            r_step <= r_step + 2'd1;
        end
    end

    // hand-off slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst_valid <= 1'b0;
        end else if (conv_done) begin
            r_burst_valid <= 1'b1;
            r_burst       <= enc_burst;
        end else if (pop_direct) begin
            r_burst_valid <= 1'b1;
            r_burst       <= dir_burst;
        end else if (burst_take) begin
            r_burst_valid <= 1'b0;
        end
    end

    // emitter walks the burst one request per cycle unless the output stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_evalid <= 1'b0;
            r_eidx   <= 3'd0;
        end else if (burst_take) begin
            r_evalid <= 1'b1;
            r_emit   <= r_burst;
            r_eidx   <= 3'd0;
        end else if (e_fire) begin
            if (e_last) begin
                r_evalid <= 1'b0;
            end else begin
                r_eidx <= r_eidx + 3'd1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_take) begin
            r_out_valid <= r_evalid;
        end
        if (e_fire) begin
            r_out.out_symbol   <= r_emit.sym[r_eidx];
            r_out.group_last   <= e_last;
            r_out.stream_last  <= e_last && r_emit.eos;
            r_out.length_error <= r_emit.lerr;
            r_out.bad_char     <= r_emit.bad;
        end
    end

    assign o_valid = r_out_valid;
    assign o_req   = r_out;

    // emitter index stays inside its burst
    a_eidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_evalid |-> (r_eidx < r_emit.n))
        else $error("emitter index past burst length");

    // bursts carry only the three legal lengths
    a_burst_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_burst_valid |-> (r_burst.n == Z85_CHARS || r_burst.n == Z85_BYTES ||
                           r_burst.n == Z85_ERR_LEN))
        else $error("illegal burst length");

    // an error request is a lone zero that closes group and stream
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.length_error) |->
            (r_out.group_last && r_out.stream_last && r_out.out_symbol == 8'd0))
        else $error("malformed error request");

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for the streaming z85 codec with a scoreboard class
`timescale 1ns / 1ps

import z85_pkg::*;

// predicts the z85 codec requests and checks them in order
class z85_codec_model;
    string       alphabet;
    logic [6:0]  digit_of [256];
    logic        decode_mode;
    logic [31:0] acc;
    int unsigned group_count;
    logic        bad_seen;
    t_out_req    expected_q [$];
    int          mismatches;

    function new();
        alphabet = {"0123456789abcdefghijklmnopqrstuvwxyz",
                    "ABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#"};
        foreach (digit_of[c]) digit_of[c] = 7'd0;
        for (int d = 0; d < 85; d++) digit_of[alphabet[d]] = 7'(d);
        decode_mode = 1'b0;
        mismatches  = 0;
        clear_group();
    endfunction

    function void clear_group();
        acc         = 32'd0;
        group_count = 0;
        bad_seen    = 1'b0;
    endfunction

    // a mode write drops any partial group, even when the mode is unchanged
    function void write_mode(input logic m);
        decode_mode = m;
        clear_group();
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void push_result(input logic [7:0] sym, input logic gl, input logic sl,
                              input logic le, input logic bc);
        t_out_req r;
        r.out_symbol   = sym;
        r.group_last   = gl;
        r.stream_last  = sl;
        r.length_error = le;
        r.bad_char     = bc;
        expected_q.push_back(r);
    endfunction

    // accepted input request: update the group and queue what it causes
    function void note_request(input t_in_req r);
        int unsigned needed;
        logic [31:0] div;
        if (decode_mode == 1'b0) begin
            acc    = {acc[23:0], r.in_symbol};
            needed = 4;
        end else begin
            // codes outside 32..127 count as digit zero and mark the group
            if (r.in_symbol >= 8'd32 && r.in_symbol <= 8'd127) begin
                acc = acc * 32'd85 + {25'd0, digit_of[r.in_symbol]};
            end else begin
                acc      = acc * 32'd85;
                bad_seen = 1'b1;
            end
            needed = 5;
        end
        group_count++;
        if (group_count >= needed) begin
            if (decode_mode == 1'b0) begin
                div = 32'd52200625;
                for (int k = 0; k < 5; k++) begin
                    push_result(alphabet[(acc / div) % 85], k == 4,
                                (k == 4) && r.end_of_stream, 1'b0, 1'b0);
                    div = div / 32'd85;
                end
            end else begin
                for (int k = 0; k < 4; k++) begin
                    push_result(acc[31 - 8 * k -: 8], k == 3,
                                (k == 3) && r.end_of_stream, 1'b0, bad_seen);
                end
            end
            clear_group();
        end else if (r.end_of_stream) begin
            // stream ended inside a group: one error request replaces it
            push_result(8'h00, 1'b1, 1'b1, 1'b1, bad_seen);
            clear_group();
        end
    endfunction

    // accepted output request: compare with the oldest prediction
    function void check_request(input t_out_req got);
        t_out_req want;
        if (expected_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected request sym %h gl %b sl %b le %b bc %b", $time,
                     got.out_symbol, got.group_last, got.stream_last,
                     got.length_error, got.bad_char);
            return;
        end
        want = expected_q.pop_front();
        if (got.out_symbol !== want.out_symbol || got.group_last !== want.group_last ||
            got.stream_last !== want.stream_last || got.length_error !== want.length_error ||
            got.bad_char !== want.bad_char) begin
            mismatches++;
            $display("%0t: expected sym %h gl %b sl %b le %b bc %b, ",
                     $time, want.out_symbol, want.group_last, want.stream_last,
                     want.length_error, want.bad_char,
                     "got sym %h gl %b sl %b le %b bc %b",
                     got.out_symbol, got.group_last,
                     got.stream_last, got.length_error, got.bad_char);
        end
    endfunction
endclass

module tb;
    localparam logic MODE_ENCODE     = 1'b0;
    localparam logic MODE_DECODE     = 1'b1;
    localparam int   DRAIN_CYCLES    = 24;
    localparam int   STUCK_LIMIT     = 5000;
    localparam int   ITEMS_PER_PHASE = 32;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_cfg_we    = 1'b0;
    logic     i_cfg_data  = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_in_req  i_in_req    = '0;
    logic     i_out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_out_req o_out_req;

    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int stuck_cycles  = 0;

    z85_codec_model model = new();

    base85_z85_codec_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_req    (i_in_req),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req),
        .i_out_stall (i_out_stall)
    );

    // clock
    always #1 i_clk = ~i_clk;

    // random receiver stall
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // request monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            model.check_request(o_out_req);
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            model.note_request(i_in_req);
        end
        if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // offer one input request, with random idle cycles first
    task automatic push_symbol(input logic [7:0] s, input logic e);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid            <= 1'b1;
        i_in_req.in_symbol     <= s;
        i_in_req.end_of_stream <= e;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // write the mode once the block has gone quiet
    task automatic set_mode(input logic m);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (model.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        model.write_mode(m);
    endtask

    // random streams, mostly whole groups ending with end of stream
    task automatic run_phase(input logic m, input int idle, input int stall, input int count);
        int         sent;
        int         kind;
        int         len;
        int         grp;
        logic [7:0] s;
        logic       e;
        set_mode(m);
        in_idle_pct   = idle;
        out_stall_pct = stall;
        sent = 0;
        grp  = (m == MODE_DECODE) ? 5 : 4;
        while (sent < count) begin
            kind = $urandom_range(99);
            if (kind < 75) len = grp * $urandom_range(1, 3);
            else len = $urandom_range(1, 3 * grp);
            for (int i = 0; i < len; i++) begin
                if (m == MODE_DECODE && $urandom_range(99) < 88)
                    s = model.alphabet[$urandom_range(84)];
                else
                    s = 8'($urandom_range(255));
                if (i == len - 1) e = (kind < 92);
                else e = (kind >= 92 && $urandom_range(5) == 0);
                push_symbol(s, e);
            end
            sent += len;
        end
    endtask

    // stimulus
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // encode: all-zero word, dropped partial group, all-ones word, short stream
        set_mode(MODE_ENCODE);
        repeat (4) push_symbol(8'h00, 1'b0);
        push_symbol(8'hAB, 1'b0);
        push_symbol(8'hCD, 1'b0);
        set_mode(MODE_ENCODE);
        repeat (3) push_symbol(8'hFF, 1'b0);
        push_symbol(8'hFF, 1'b1);
        push_symbol(8'h86, 1'b0);
        push_symbol(8'h4F, 1'b1);

        // decode: overflowing group, out-of-range and unassigned codes, short stream
        set_mode(MODE_DECODE);
        repeat (5) push_symbol(8'h23, 1'b0);     // '#' is digit 84
        push_symbol(8'h00, 1'b0);
        push_symbol(8'h7F, 1'b0);
        push_symbol(8'h20, 1'b0);
        push_symbol(8'hFF, 1'b0);
        push_symbol(8'h61, 1'b1);
        push_symbol(8'h80, 1'b0);
        push_symbol(8'h1F, 1'b1);

        // random phases under each idling pattern
        for (int pass = 0; pass < 4; pass++) begin
            case (pass)
                0: begin
                    run_phase(MODE_ENCODE, 0, 0, ITEMS_PER_PHASE);
                    run_phase(MODE_DECODE, 0, 0, ITEMS_PER_PHASE);
                end
                1: begin
                    run_phase(MODE_DECODE, 57, 0, ITEMS_PER_PHASE);
                    run_phase(MODE_ENCODE, 57, 0, ITEMS_PER_PHASE);
                end
                2: begin
                    run_phase(MODE_ENCODE, 0, 57, ITEMS_PER_PHASE);
                    run_phase(MODE_DECODE, 0, 57, ITEMS_PER_PHASE);
                end
                default: begin
                    run_phase(MODE_DECODE, 7, 7, ITEMS_PER_PHASE);
                    run_phase(MODE_ENCODE, 7, 7, ITEMS_PER_PHASE);
                end
            endcase
        end

        // drain
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (model.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (model.mismatches == 0 && model.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
sv/z85_pkg.sv
sv/z85_front.sv
sv/z85_fifo.sv
sv/z85_back.sv
sv/base85_z85_codec_top.sv
tb/sv/tb.sv
